[src/pcc_pkg.sv]
// ----------------------------------------------------------------------------
// pcc_pkg: shared types and constants for the port contention block
// request/result structs, queue and divider handshakes, state encodings
// ----------------------------------------------------------------------------
`default_nettype none

package pcc_pkg;

  localparam int NUM_PORTS   = 7;
  localparam int COUNT_WIDTH = 16;
  localparam int LEN_W       = 20;
  localparam int CONTRIB_W   = 64;

  localparam int PIDX_W = $clog2(NUM_PORTS);
  localparam int NP_W   = $clog2(NUM_PORTS + 1);
  // sum of up to four counters
  localparam int SUM_W  = COUNT_WIDTH + 2;
  // effective length: path length or a bound derived from the counters
  localparam int EFF_W  = (LEN_W > COUNT_WIDTH + 1) ? LEN_W : COUNT_WIDTH + 1;
  localparam int PROD_W = LEN_W + EFF_W;
  // dividend of the contribution fraction
  localparam int SH_W   = LEN_W;
  localparam int STEP_W = $clog2(SH_W + 1);

  // divide by three as a multiply by a rounded-up reciprocal
  localparam int                 RECIP3_SH = SUM_W + 1;
  localparam int                 PROD3_W   = 2 * SUM_W;
  localparam logic [SUM_W-1:0]   RECIP3    =
    SUM_W'(((64'd1 << RECIP3_SH) + 64'd2) / 64'd3);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int MILLION = 1000000;
  localparam int LEN_MAX = (1 << LEN_W) - 1;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  localparam logic [PIDX_W-1:0] PORT_0   = PIDX_W'(0);
  localparam logic [PIDX_W-1:0] PORT_1   = PIDX_W'(1);
  localparam logic [PIDX_W-1:0] PORT_5   = PIDX_W'(2);
  localparam logic [PIDX_W-1:0] PORT_05  = PIDX_W'(3);
  localparam logic [PIDX_W-1:0] PORT_015 = PIDX_W'(4);
  localparam logic [2:0]        NO_PORT  = 3'd7;

  localparam logic [STEP_W-1:0] FRAC_STEPS = STEP_W'(LEN_W);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    op_t              operation;
    logic [2:0]       port;
    logic [LEN_W-1:0] path_length;
    logic             record_reason;
  } in_req_t;

  typedef struct packed {
    logic [LEN_W-1:0]     effective_length;
    logic [2:0]           limiting_port;
    logic [CONTRIB_W-1:0] contribution_total;
  } out_rsp_t;

  typedef struct packed {
    logic [LEN_W-1:0]  path_length;
    logic              record_reason;
    logic [EFF_W-1:0]  eff;
    logic [PIDX_W-1:0] who;
    logic              no_port;
    logic [SUM_W-1:0]  use05;
    logic [SUM_W-1:0]  use015;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

  typedef struct packed {
    logic     full;
    logic     empty;
    q_entry_t head;
  } q_status_t;

  typedef struct packed {
    logic              start;
    logic [EFF_W-1:0]  rem_init;
    logic [SH_W-1:0]   dividend;
    logic [EFF_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_cmd_t;

  typedef struct packed {
    logic            done;
    logic [SH_W-1:0] quotient;
  } div_sts_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SCAN,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_R05,
    B_R015,
    B_PREP,
    B_DIV,
    B_ACC,
    B_FIN
  } back_state_t;

endpackage

`default_nettype wire

[src/pcc_front.sv]
// ----------------------------------------------------------------------------
// pcc_front: request intake and per-port micro-op counters
// applies add/remove/clear at once, scans the counters for a query
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_front import pcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_req_t   in_data,
  output q_push_t   q_push,
  input  q_status_t q_status
);

  front_state_t      state_r, state_nxt;
  count_t            counts_r [NUM_PORTS];
  count_t            counts_nxt [NUM_PORTS];
  logic [PIDX_W-1:0] scan_r, scan_nxt;
  logic [EFF_W-1:0]  eff_r, eff_nxt;
  logic [PIDX_W-1:0] who_r, who_nxt;
  logic              none_r, none_nxt;
  logic [LEN_W-1:0]  path_r, path_nxt;
  logic              rec_r, rec_nxt;
  logic [SUM_W-1:0]  use05_r, use05_nxt;
  logic [SUM_W-1:0]  use015_r, use015_nxt;

  logic              accept;
  logic              in_range;
  logic [PIDX_W-1:0] rd_idx;
  count_t            rd_cnt;
  logic              last_scan;
  logic              dedicated;

  assign accept    = in_valid && in_ready;
  assign in_range  = NP_W'(in_data.port) < NP_W'(NUM_PORTS);
  assign rd_idx    = (state_r == F_SCAN) ? scan_r : PIDX_W'(in_data.port);
  assign rd_cnt    = counts_r[rd_idx];
  assign last_scan = scan_r == PIDX_W'(NUM_PORTS - 1);
  assign dedicated = (scan_r != PORT_05) && (scan_r != PORT_015);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept && in_data.operation == OP_QUERY) state_nxt = F_SCAN;
      end
      F_SCAN: begin
        if (last_scan) state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_status.full) state_nxt = F_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready                   = state_r == F_IDLE;
    q_push.valid               = (state_r == F_PUSH) && !q_status.full;
    q_push.entry.path_length   = path_r;
    q_push.entry.record_reason = rec_r;
    q_push.entry.eff           = eff_r;
    q_push.entry.who           = who_r;
    q_push.entry.no_port       = none_r;
    q_push.entry.use05         = use05_r;
    q_push.entry.use015        = use015_r;
  end

  // counters and scan datapath
  always_comb begin
    counts_nxt = counts_r;
    scan_nxt   = scan_r;
    eff_nxt    = eff_r;
    who_nxt    = who_r;
    none_nxt   = none_r;
    path_nxt   = path_r;
    rec_nxt    = rec_r;
    use05_nxt  = use05_r;
    use015_nxt = use015_r;
    if (accept) begin
      unique case (in_data.operation)
        OP_ADD: begin
          if (in_range && rd_cnt != COUNT_MAX) counts_nxt[rd_idx] = rd_cnt + 1'b1;
        end
        OP_REMOVE: begin
          if (in_range && rd_cnt != '0) counts_nxt[rd_idx] = rd_cnt - 1'b1;
        end
        OP_CLEAR: begin
          for (int i = 0; i < NUM_PORTS; i++) counts_nxt[i] = '0;
        end
        OP_QUERY: begin
          scan_nxt   = '0;
          eff_nxt    = EFF_W'(in_data.path_length);
          who_nxt    = '0;
          none_nxt   = 1'b1;
          path_nxt   = in_data.path_length;
          rec_nxt    = in_data.record_reason;
          use05_nxt  = SUM_W'(counts_r[PORT_0]) + SUM_W'(counts_r[PORT_5])
                     + SUM_W'(counts_r[PORT_05]);
          use015_nxt = SUM_W'(counts_r[PORT_0]) + SUM_W'(counts_r[PORT_1])
                     + SUM_W'(counts_r[PORT_5]) + SUM_W'(counts_r[PORT_015]);
        end
      endcase
    end else if (state_r == F_SCAN) begin
      // strict compare keeps the lowest port on ties
      if (dedicated && eff_r < EFF_W'(rd_cnt)) begin
        eff_nxt  = EFF_W'(rd_cnt);
        who_nxt  = scan_r;
        none_nxt = 1'b0;
      end
      if (!last_scan) scan_nxt = scan_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      for (int i = 0; i < NUM_PORTS; i++) counts_r[i] <= '0;
    end else begin
      state_r  <= state_nxt;
      counts_r <= counts_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r   <= scan_nxt;
    eff_r    <= eff_nxt;
    who_r    <= who_nxt;
    none_r   <= none_nxt;
    path_r   <= path_nxt;
    rec_r    <= rec_nxt;
    use05_r  <= use05_nxt;
    use015_r <= use015_nxt;
  end

endmodule

`default_nettype wire

[src/pcc_queue.sv]
// ----------------------------------------------------------------------------
// pcc_queue: short queue of classified queries
// decouples the counter scan from the contention arithmetic
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_queue import pcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_push_t   q_push,
  input  logic      q_pop,
  output q_status_t q_status
);

  q_entry_t          mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (q_push.valid) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (q_push.valid && !q_pop) cnt_nxt = cnt_r + 1'b1;
    else if (q_pop && !q_push.valid) cnt_nxt = cnt_r - 1'b1;
  end

  assign q_status.full  = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign q_status.empty = cnt_r == '0;
  assign q_status.head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.valid) mem_r[wr_ptr_r] <= q_push.entry;
  end

endmodule

`default_nettype wire

[src/pcc_div.sv]
// ----------------------------------------------------------------------------
// pcc_div: restoring divider, one quotient bit per cycle
// serves the contribution fraction
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_div import pcc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_cmd_t cmd,
  output div_sts_t sts
);

  logic [EFF_W-1:0]  rem_r;
  logic [SH_W-1:0]   dq_r;
  logic [EFF_W-1:0]  dvs_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [EFF_W:0]    rem_ext;
  logic [EFF_W:0]    rem_sub;
  logic              ge;
  logic [EFF_W-1:0]  rem_step;
  logic [SH_W-1:0]   dq_step;

  // dividend bits shift out of the top, quotient bits in at the bottom
  always_comb begin
    rem_ext  = {rem_r, dq_r[SH_W-1]};
    rem_sub  = rem_ext - {1'b0, dvs_r};
    ge       = rem_ext >= {1'b0, dvs_r};
    rem_step = ge ? rem_sub[EFF_W-1:0] : rem_ext[EFF_W-1:0];
    dq_step  = {dq_r[SH_W-2:0], ge};
  end

  assign sts.done     = done_r;
  assign sts.quotient = dq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && cnt_r == STEP_W'(1);
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= cmd.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem_r <= cmd.rem_init;
      dq_r  <= cmd.dividend;
      dvs_r <= cmd.divisor;
    end else if (busy_r) begin
      rem_r <= rem_step;
      dq_r  <= dq_step;
    end
  end

endmodule

`default_nettype wire

[src/pcc_back.sv]
// ----------------------------------------------------------------------------
// pcc_back: shared-port limits, contribution accumulators, result register
// runs one query at a time, the contribution fraction through the divider
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_back import pcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_status_t q_status,
  output logic      q_pop,
  output div_cmd_t  div_cmd,
  input  div_sts_t  div_sts,
  output logic      out_valid,
  input  logic      out_ready,
  output out_rsp_t  out_data
);

  back_state_t          state_r, state_nxt;
  logic [LEN_W-1:0]     path_r;
  logic                 rec_r;
  logic [EFF_W-1:0]     eff_r;
  logic [PIDX_W-1:0]    who_r;
  logic                 none_r;
  logic [SUM_W-1:0]     use05_r;
  logic [SUM_W-1:0]     use015_r;
  logic [CONTRIB_W-1:0] contrib_r [NUM_PORTS];
  logic                 out_valid_r;
  out_rsp_t             out_data_r;

  logic [EFF_W+1:0]     twice_eff;
  logic [EFF_W+1:0]     thrice_eff;
  logic                 need05;
  logic                 need015;
  logic [SUM_W:0]       inc05;
  logic [EFF_W-1:0]     ceil05;
  logic [SUM_W-1:0]     inc015;
  logic [PROD3_W-1:0]   prod3;
  logic [EFF_W-1:0]     ceil015;
  logic [EFF_W-1:0]     diff;
  logic [PROD_W-1:0]    prod;
  logic                 extended;
  logic                 do_frac;
  logic                 out_free;
  logic                 sat;

  always_comb begin
    twice_eff  = {1'b0, eff_r, 1'b0};
    thrice_eff = {2'b00, eff_r} + {1'b0, eff_r, 1'b0};
    need05     = (EFF_W + 2)'(use05_r) > twice_eff;
    need015    = (EFF_W + 2)'(use015_r) > thrice_eff;
    inc05      = {1'b0, use05_r} + (SUM_W + 1)'(1);
    ceil05     = EFF_W'(inc05[SUM_W:1]);
    inc015     = use015_r + SUM_W'(2);
    // ceiling of a third as floor of (sum + 2) / 3, by reciprocal multiply
    prod3      = PROD3_W'(inc015) * PROD3_W'(RECIP3);
    ceil015    = EFF_W'(prod3[PROD3_W-1:RECIP3_SH]);
    diff       = eff_r - EFF_W'(path_r);
    prod       = PROD_W'(MILLION) * PROD_W'(diff);
    extended   = !none_r;
    do_frac    = extended && rec_r;
    out_free   = !out_valid_r || out_ready;
    sat        = eff_r > EFF_W'(LEN_MAX);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: if (!q_status.empty) state_nxt = B_R05;
      B_R05:  state_nxt = B_R015;
      B_R015: state_nxt = B_PREP;
      B_PREP: state_nxt = do_frac ? B_DIV : B_FIN;
      B_DIV:  if (div_sts.done) state_nxt = B_ACC;
      B_ACC:  state_nxt = B_FIN;
      B_FIN:  if (out_free) state_nxt = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop            = (state_r == B_IDLE) && !q_status.empty;
    div_cmd.start    = (state_r == B_PREP) && do_frac;
    // quotient is below 2^LEN_W, so the high part already sits below eff
    div_cmd.rem_init = prod[PROD_W-1:LEN_W];
    div_cmd.dividend = prod[LEN_W-1:0];
    div_cmd.divisor  = eff_r;
    div_cmd.steps    = FRAC_STEPS;
    out_valid = out_valid_r;
    out_data  = out_data_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_PORTS; i++) contrib_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_FIN && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (state_r == B_ACC) begin
        contrib_r[who_r] <= contrib_r[who_r] + CONTRIB_W'(div_sts.quotient[LEN_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        if (!q_status.empty) begin
          path_r   <= q_status.head.path_length;
          rec_r    <= q_status.head.record_reason;
          eff_r    <= q_status.head.eff;
          who_r    <= q_status.head.who;
          none_r   <= q_status.head.no_port;
          use05_r  <= q_status.head.use05;
          use015_r <= q_status.head.use015;
        end
      end
      B_R05: begin
        if (need05) begin
          eff_r  <= ceil05;
          who_r  <= PORT_05;
          none_r <= 1'b0;
        end
      end
      B_R015: begin
        if (need015) begin
          eff_r  <= ceil015;
          who_r  <= PORT_015;
          none_r <= 1'b0;
        end
      end
      B_PREP: begin
      end
      B_DIV: begin
      end
      B_ACC: begin
      end
      B_FIN: begin
        if (out_free) begin
          out_data_r.effective_length   <= sat ? LEN_W'(LEN_MAX) : eff_r[LEN_W-1:0];
          out_data_r.limiting_port      <= extended ? who_r[2:0] : NO_PORT;
          out_data_r.contribution_total <= extended ? contrib_r[who_r] : '0;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

[src/port_contention_critical_path.sv]
// ----------------------------------------------------------------------------
// port_contention_critical_path: issue port contention limit on a path
// per-port micro-op counters and a contention-extended critical path query
// ----------------------------------------------------------------------------
// usage
//   in_*  : valid/ready request channel; operation add, remove, clear or
//           query. add/remove/clear give no result.
//   out_* : valid/ready result channel, one result per query request.
// query path
//   a query passes the front (counter scan through one shared read port),
//   then the back, and the divider as well when a recorded contribution
//   needs the fraction; the single-bit restoring divider sets the long end.
// flow
//   the front takes a counter request every cycle while it is not scanning
//   or pushing a query; a query holds the front until it is queued, and
//   a two-entry queue lets the front run ahead of the back.
// reset
//   synchronous, active low; clears all counters and accumulators.
// stall
//   a held result sits in the output register while the back starts the
//   next query; the back then waits in its last step, the queue fills and
//   the front holds in_ready low after the following query.
// ----------------------------------------------------------------------------
`default_nettype none

module port_contention_critical_path import pcc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_rsp_t out_data
);

  // front to queue
  q_push_t   q_push;
  q_status_t q_status;
  // queue to back
  logic      q_pop;
  // back to divider
  div_cmd_t  div_cmd;
  div_sts_t  div_sts;

  // counters, request intake and counter scan
  pcc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_status (q_status)
  );

  // classified queries waiting for the back
  pcc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_push   (q_push),
    .q_pop    (q_pop),
    .q_status (q_status)
  );

  // one bit per cycle divider for the contribution fraction
  pcc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (div_cmd),
    .sts   (div_sts)
  );

  // shared-port limits, accumulators and the result register
  pcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_pop     (q_pop),
    .div_cmd   (div_cmd),
    .div_sts   (div_sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[src/pcc_checker.sv]
// ----------------------------------------------------------------------------
// pcc_checker: port-level checks for the port contention block
// attached to the top level by bind
// ----------------------------------------------------------------------------
`default_nettype none

module pcc_checker import pcc_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input in_req_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input out_rsp_t out_data
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // only a query request closes the input
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid && in_data.operation == OP_QUERY))
    else $error("input closed without a query");

  // counter requests never block the input
  a_counter_open: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.operation != OP_QUERY |=> in_ready)
    else $error("input closed after a counter request");

  // with at most seven ports, no limiting port means no contribution
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && NUM_PORTS <= 7 && out_data.limiting_port == NO_PORT
    |-> out_data.contribution_total == '0)
    else $error("contribution reported without a limiting port");

endmodule

bind port_contention_critical_path pcc_checker u_pcc_checker (.*);

`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: port contention critical path testbench
// drives counter and query requests with random gaps and checks every query
// result (limited length, limiting port, contribution total) against an
// in-bench tracker of the per-port counters and contribution accumulators
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import pcc_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int PAUSE_AT     = 800;
  localparam int BURST_UNTIL  = 1000;
  localparam int BURST_ADDS   = 150;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 100;

  // dedicated port codes with no name in the package, and a code outside the counters
  localparam logic [2:0] PORT_DED_A   = 3'd5;
  localparam logic [2:0] PORT_DED_B   = 3'd6;
  localparam logic [2:0] PORT_OUTSIDE = 3'd7;

  typedef struct {
    in_req_t     req;
    int unsigned gap;
  } pending_req_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_req_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_rsp_t out_data;

  // tracked block state
  count_t          uop_count    [NUM_PORTS];
  longint unsigned port_contrib [NUM_PORTS];

  out_rsp_t     expected_limits [$];
  pending_req_t pending_reqs    [$];

  // sender state
  pending_req_t head_req;
  bit           staged    = 1'b0;
  int unsigned  gap_left  = 0;
  bit           req_taken = 1'b0;

  // receiver state
  bit          hold_request = 1'b0;
  int unsigned stall_left   = 0;

  bit          no_idle        = 1'b0;
  int unsigned stim_count     = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  port_contention_critical_path i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // mostly short idle stretches, now and then a long one
  function automatic int unsigned idle_length();
    if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic int unsigned sender_gap();
    if (no_idle || $urandom_range(0, 1) == 0) return 0;
    return idle_length();
  endfunction

  // update the tracked counters for one accepted request and, for a query,
  // queue the limited length, the limiting port and the contribution total
  task automatic track_request(input in_req_t req);
    longint unsigned eff;
    longint unsigned use05;
    longint unsigned use015;
    int              limit_port;
    out_rsp_t        rsp;
    case (req.operation)
      OP_ADD: begin
        if (req.port < NUM_PORTS && uop_count[req.port] != COUNT_MAX)
          uop_count[req.port] = uop_count[req.port] + 1'b1;
      end
      OP_REMOVE: begin
        if (req.port < NUM_PORTS && uop_count[req.port] != '0)
          uop_count[req.port] = uop_count[req.port] - 1'b1;
      end
      OP_CLEAR: begin
        foreach (uop_count[p]) uop_count[p] = '0;
      end
      OP_QUERY: begin
        // largest dedicated count, lowest port on a tie
        eff = 64'(req.path_length);
        limit_port = NO_PORT;
        for (int p = 0; p < NUM_PORTS; p++) begin
          if (p != PORT_05 && p != PORT_015 && eff < 64'(uop_count[p])) begin
            eff = 64'(uop_count[p]);
            limit_port = p;
          end
        end
        // two ports share the 05 micro-ops
        use05 = 64'(uop_count[PORT_0]) + 64'(uop_count[PORT_5])
              + 64'(uop_count[PORT_05]);
        if (use05 > 2 * eff) begin
          eff = (use05 + 1) / 2;
          limit_port = PORT_05;
        end
        // three ports share the 015 micro-ops
        use015 = 64'(uop_count[PORT_0]) + 64'(uop_count[PORT_1])
               + 64'(uop_count[PORT_5]) + 64'(uop_count[PORT_015]);
        if (use015 > 3 * eff) begin
          eff = (use015 + 2) / 3;
          limit_port = PORT_015;
        end
        rsp.contribution_total = '0;
        if (eff > 64'(req.path_length) && limit_port < NUM_PORTS) begin
          if (req.record_reason)
            port_contrib[limit_port] += (64'(MILLION) * (eff - 64'(req.path_length))) / eff;
          rsp.contribution_total = port_contrib[limit_port];
        end
        rsp.effective_length = (eff > LEN_MAX) ? LEN_W'(LEN_MAX) : LEN_W'(eff);
        rsp.limiting_port = 3'(limit_port);
        expected_limits.push_back(rsp);
      end
    endcase
  endtask

  task automatic offer(input op_t op, input logic [2:0] port,
                       input logic [LEN_W-1:0] path, input logic rec);
    pending_req_t item;
    item.req.operation = op;
    item.req.port = port;
    item.req.path_length = path;
    item.req.record_reason = rec;
    item.gap = sender_gap();
    pending_reqs.push_back(item);
    // add or remove on a port with no counter changes nothing
    if (!((op == OP_ADD || op == OP_REMOVE) && port >= NUM_PORTS)) stim_count++;
  endtask

  // sender pause: nothing pending, nothing offered, no result outstanding
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || staged || in_valid || expected_limits.size() != 0)
      @(posedge clk);
  endtask

  task automatic random_traffic(input int unsigned upto);
    int unsigned pick;
    logic [2:0]  burst_port;
    while (stim_count < upto) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        // load one port with a run of adds and a few removes, then query
        // with a short path so the counters decide the result
        burst_port = 3'($urandom_range(0, 6));
        repeat ($urandom_range(1, 12))
          offer(($urandom_range(0, 3) == 0) ? OP_REMOVE : OP_ADD, burst_port,
                LEN_W'($urandom()), 1'($urandom()));
        offer(OP_QUERY, 3'($urandom_range(0, 7)), LEN_W'($urandom_range(0, 40)),
              1'($urandom_range(0, 1)));
      end else if (pick < 85) begin
        // loose request of any kind
        offer(op_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
              LEN_W'($urandom_range(0, 60)), 1'($urandom_range(0, 1)));
      end else if (pick < 95) begin
        // full-range path length, mostly beyond every counter
        offer(OP_QUERY, 3'($urandom_range(0, 7)), LEN_W'($urandom()),
              1'($urandom_range(0, 1)));
      end else begin
        offer(OP_CLEAR, 3'($urandom_range(0, 7)), LEN_W'($urandom()),
              1'($urandom_range(0, 1)));
      end
    end
  endtask

  // request driver: new values at the falling edge, valid held until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      req_taken = 1'b0;
      if (!staged && pending_reqs.size() != 0) begin
        head_req = pending_reqs.pop_front();
        gap_left = head_req.gap;
        staged = 1'b1;
      end
      if (staged && gap_left == 0) begin
        in_data <= head_req.req;
        in_valid <= 1'b1;
        staged = 1'b0;
      end else begin
        if (staged) gap_left--;
        in_valid <= 1'b0;
      end
    end
  end

  // result side ready: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_request) begin
        stall_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 99) < 25) begin
        stall_left = idle_length() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // both handshakes sampled at the rising edge
  always @(posedge clk) begin : watch_channels
    out_rsp_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_limits.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with no query outstanding: length %0d port %0d total %0d",
                   $time, out_data.effective_length, out_data.limiting_port,
                   out_data.contribution_total);
        end else begin
          want = expected_limits.pop_front();
          if (out_data.effective_length !== want.effective_length) begin
            mismatch_count++;
            $display("%0t: effective_length expected %0d actual %0d", $time,
                     want.effective_length, out_data.effective_length);
          end
          if (out_data.limiting_port !== want.limiting_port) begin
            mismatch_count++;
            $display("%0t: limiting_port expected %0d actual %0d", $time,
                     want.limiting_port, out_data.limiting_port);
          end
          if (out_data.contribution_total !== want.contribution_total) begin
            mismatch_count++;
            $display("%0t: contribution_total expected %0d actual %0d", $time,
                     want.contribution_total, out_data.contribution_total);
          end
        end
      end
      if (in_valid && in_ready) begin
        track_request(in_data);
        req_taken = 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    foreach (uop_count[p]) begin
      uop_count[p] = '0;
      port_contrib[p] = '0;
    end
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty counters leave the path alone, even at full length
    offer(OP_QUERY, PORT_0, '0, 1'b1);
    offer(OP_QUERY, PORT_DED_B, {LEN_W{1'b1}}, 1'b1);
    // remove at zero holds; a port with no counter is ignored
    offer(OP_REMOVE, PORT_0, '0, 1'b0);
    offer(OP_ADD, PORT_OUTSIDE, '0, 1'b0);
    offer(OP_REMOVE, PORT_OUTSIDE, '0, 1'b0);
    // equal dedicated counts on port 0 and port 1: port 0 wins
    offer(OP_ADD, PORT_0, '0, 1'b0);
    offer(OP_ADD, PORT_1, '0, 1'b0);
    offer(OP_QUERY, PORT_0, '0, 1'b1);
    // shared 05 micro-ops push past the dedicated bound
    offer(OP_ADD, PORT_05, '0, 1'b0);
    offer(OP_ADD, PORT_05, '0, 1'b0);
    offer(OP_QUERY, PORT_05, '0, 1'b1);
    offer(OP_QUERY, PORT_05, '0, 1'b0);
    // after a clear, the 015 bound alone extends a zero path
    offer(OP_CLEAR, PORT_0, '0, 1'b0);
    offer(OP_ADD, PORT_015, '0, 1'b0);
    offer(OP_QUERY, PORT_015, '0, 1'b1);
    offer(OP_REMOVE, PORT_015, '0, 1'b0);
    offer(OP_REMOVE, PORT_015, '0, 1'b0);
    // tie between the dedicated ports, then a path that equals the count
    offer(OP_ADD, PORT_DED_A, '0, 1'b0);
    offer(OP_ADD, PORT_DED_B, '0, 1'b0);
    offer(OP_QUERY, PORT_DED_A, '0, 1'b1);
    offer(OP_QUERY, PORT_DED_B, LEN_W'(1), 1'b1);
    wait_drained();

    // back-to-back adds build up one dedicated counter
    no_idle = 1'b1;
    repeat (BURST_ADDS) offer(OP_ADD, PORT_DED_B, '0, 1'b0);
    offer(OP_QUERY, PORT_0, '0, 1'b1);
    offer(OP_REMOVE, PORT_DED_B, '0, 1'b0);
    offer(OP_QUERY, PORT_0, LEN_W'(70000), 1'b1);
    offer(OP_QUERY, PORT_0, LEN_W'(3), 1'b1);
    offer(OP_CLEAR, PORT_0, '0, 1'b0);
    wait_drained();

    // long hold-off on results while queries keep arriving: the block
    // fills up and must drop in_ready
    hold_request = 1'b1;
    repeat (3) offer(OP_ADD, PORT_0, '0, 1'b0);
    repeat (24) offer(OP_QUERY, 3'($urandom_range(0, 7)), LEN_W'($urandom_range(0, 4)),
                      1'($urandom_range(0, 1)));
    wait_drained();
    no_idle = 1'b0;

    // random traffic, with a sender pause and an idle-free stretch inside
    stim_count = 0;
    random_traffic(PAUSE_AT);
    wait_drained();
    no_idle = 1'b1;
    random_traffic(BURST_UNTIL);
    wait_drained();
    no_idle = 1'b0;
    random_traffic(RANDOM_ITEMS);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_limits.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
